/* design/uite_pkg.sv */
// ----------------------------------------------------------------------------
// UART interrupt transfer engine package
// Shared codes, field widths and the item and result types.
// ----------------------------------------------------------------------------
package uite_pkg;

   localparam int SEND_DEPTH_DEFAULT = 256;

   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 16;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD     = 2'd0,
      ACT_RX_START = 2'd1,
      ACT_RX_ABORT = 2'd2,
      ACT_EVENT    = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BUSY    = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [BYTE_W-1:0]  load_byte;
      logic               load_last;
      logic [COUNT_W-1:0] receive_count;
      logic               flag_tx_empty;
      logic               flag_rx_full;
      logic               flag_tx_complete;
      logic               flag_rx_error;
      logic [BYTE_W-1:0]  rx_byte;
   } item_type;

   typedef struct packed {
      status_type         cmd_status;
      logic               send_valid;
      logic [BYTE_W-1:0]  send_byte;
      logic               store_valid;
      logic [COUNT_W-1:0] store_index;
      logic [BYTE_W-1:0]  store_byte;
      logic               txe_irq_enable;
      logic               tc_irq_enable;
      logic               rxne_irq_enable;
      logic               clear_tc;
      logic               sending;
      logic               receiving;
   } result_type;

endpackage

/* design/uite_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered (read-first).
// ----------------------------------------------------------------------------
module uite_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* design/uite_core.sv */
// ----------------------------------------------------------------------------
// Transfer engine core
// Transmit and receive control state and the single-pass update per item.
// ----------------------------------------------------------------------------
module uite_core
   import uite_pkg::*;
#(
   parameter int SEND_DEPTH = SEND_DEPTH_DEFAULT,
   parameter int ADDR_W     = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1,
   parameter int CNT_W      = $clog2(SEND_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              process,
   input  item_type          item,
   input  logic [BYTE_W-1:0] rd_data,
   output logic [ADDR_W-1:0] rd_addr,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [BYTE_W-1:0] wr_data,
   output result_type        result
);

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SEND_DEPTH);

   logic [CNT_W-1:0]   load_count_ff, load_count_in;
   logic [CNT_W-1:0]   send_length_ff, send_length_in;
   logic [CNT_W-1:0]   send_position_ff, send_position_in;
   logic               send_busy_ff, send_busy_in;
   logic               send_armed_ff, send_armed_in;
   logic               txe_en_ff, txe_en_in;
   logic               tc_en_ff, tc_en_in;
   logic               recv_armed_ff, recv_armed_in;
   logic               recv_busy_ff, recv_busy_in;
   logic               rxne_en_ff, rxne_en_in;
   logic [COUNT_W-1:0] recv_length_ff, recv_length_in;
   logic [COUNT_W-1:0] recv_position_ff, recv_position_in;
   logic [COUNT_W:0]   recv_next;

   assign recv_next = {1'b0, recv_position_ff} + 1'b1;

   always_comb begin
      load_count_in    = load_count_ff;
      send_length_in   = send_length_ff;
      send_position_in = send_position_ff;
      send_busy_in     = send_busy_ff;
      send_armed_in    = send_armed_ff;
      txe_en_in        = txe_en_ff;
      tc_en_in         = tc_en_ff;
      recv_armed_in    = recv_armed_ff;
      recv_busy_in     = recv_busy_ff;
      rxne_en_in       = rxne_en_ff;
      recv_length_in   = recv_length_ff;
      recv_position_in = recv_position_ff;
      result           = '0;
      result.cmd_status = ST_OK;
      wr_en            = 1'b0;
      wr_addr          = load_count_ff[ADDR_W-1:0];
      wr_data          = item.load_byte;

      if (process) begin
         case (item.action)
            ACT_LOAD: begin
               if (!item.load_last) begin
                  if (send_busy_ff) begin
                     result.cmd_status = ST_BUSY;
                  end else if (load_count_ff >= DEPTH_CNT) begin
                     result.cmd_status = ST_INVALID;
                  end else begin
                     wr_en         = 1'b1;
                     load_count_in = load_count_ff + 1'b1;
                  end
               end else if (load_count_ff >= DEPTH_CNT) begin
                  load_count_in     = '0;
                  result.cmd_status = ST_INVALID;
               end else begin
                  send_armed_in = 1'b1;
                  load_count_in = '0;
                  if (send_busy_ff) begin
                     result.cmd_status = ST_BUSY;
                  end else begin
                     wr_en            = 1'b1;
                     send_length_in   = load_count_ff + 1'b1;
                     send_position_in = '0;
                     send_busy_in     = 1'b1;
                     txe_en_in        = 1'b1;
                  end
               end
            end
            ACT_RX_START: begin
               if (item.receive_count == '0) begin
                  result.cmd_status = ST_INVALID;
               end else begin
                  recv_armed_in = 1'b1;
                  if (recv_busy_ff) begin
                     result.cmd_status = ST_BUSY;
                  end else begin
                     recv_length_in   = item.receive_count;
                     recv_position_in = '0;
                     recv_busy_in     = 1'b1;
                     rxne_en_in       = 1'b1;
                  end
               end
            end
            ACT_RX_ABORT: begin
               rxne_en_in       = 1'b0;
               recv_armed_in    = 1'b0;
               recv_length_in   = '0;
               recv_position_in = '0;
               recv_busy_in     = 1'b0;
            end
            ACT_EVENT: begin
               // transmit empty: hand out the next byte or switch to TC
               if (send_armed_ff && item.flag_tx_empty) begin
                  if (send_position_ff < send_length_ff) begin
                     result.send_valid = 1'b1;
                     result.send_byte  = rd_data;
                     send_position_in  = send_position_ff + 1'b1;
                  end else begin
                     txe_en_in = 1'b0;
                     tc_en_in  = 1'b1;
                  end
               end
               if (recv_armed_ff && item.flag_rx_full) begin
                  if (item.flag_rx_error) begin
                     rxne_en_in   = 1'b0;
                     recv_busy_in = 1'b0;
                  end else if (recv_busy_ff && (recv_position_ff < recv_length_ff)) begin
                     result.store_valid = 1'b1;
                     result.store_index = recv_position_ff;
                     result.store_byte  = item.rx_byte;
                     recv_position_in   = recv_next[COUNT_W-1:0];
                     if (recv_next >= {1'b0, recv_length_ff}) begin
                        rxne_en_in   = 1'b0;
                        recv_busy_in = 1'b0;
                     end
                  end
               end
               // transmission complete counts only once every byte is out
               if (send_armed_ff && item.flag_tx_complete &&
                   (send_position_in >= send_length_ff)) begin
                  tc_en_in        = 1'b0;
                  result.clear_tc = 1'b1;
                  send_busy_in    = 1'b0;
               end
            end
            default: begin
               result.cmd_status = ST_OK;
            end
         endcase
      end

      result.txe_irq_enable  = txe_en_in;
      result.tc_irq_enable   = tc_en_in;
      result.rxne_irq_enable = rxne_en_in;
      result.sending         = send_busy_in;
      result.receiving       = recv_busy_in;
   end

   // prefetch the byte at the next send position
   assign rd_addr = send_position_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff    <= '0;
         send_length_ff   <= '0;
         send_position_ff <= '0;
         send_busy_ff     <= 1'b0;
         send_armed_ff    <= 1'b0;
         txe_en_ff        <= 1'b0;
         tc_en_ff         <= 1'b0;
         recv_armed_ff    <= 1'b0;
         recv_busy_ff     <= 1'b0;
         rxne_en_ff       <= 1'b0;
         recv_length_ff   <= '0;
         recv_position_ff <= '0;
      end else begin
         load_count_ff    <= load_count_in;
         send_length_ff   <= send_length_in;
         send_position_ff <= send_position_in;
         send_busy_ff     <= send_busy_in;
         send_armed_ff    <= send_armed_in;
         txe_en_ff        <= txe_en_in;
         tc_en_ff         <= tc_en_in;
         recv_armed_ff    <= recv_armed_in;
         recv_busy_ff     <= recv_busy_in;
         rxne_en_ff       <= rxne_en_in;
         recv_length_ff   <= recv_length_in;
         recv_position_ff <= recv_position_in;
      end
   end

endmodule

/* design/uart_interrupt_transfer_engine.sv */
// ----------------------------------------------------------------------------
// UART interrupt transfer engine
// Buffered transmit and counted receive control for an interrupt-driven UART.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per handshake: a transmit byte load (tlast marks
//   the last byte and starts the send), a receive start with a byte count, a
//   receive abort, or a UART status event with its flags and received byte.
//   tuser holds the action code.
//   rsp_* returns exactly one result item per request item: command status,
//   the byte handed to the UART data register, the received byte and its
//   store index, the current interrupt enables, the TC clear request and the
//   busy flags.
//   A request item passes through the input register and then the result
//   register, which holds it until rsp_tready takes it. One item is taken
//   every cycle while the result register is free or drains; the send buffer
//   RAM is read ahead at the next send position, with a same-cycle write bypass.
//   Reset clears all control state and both valid flags; buffer contents are
//   not cleared. When rsp_tready is low, the result register holds its item,
//   the input register holds one more item, and then req_tready drops.
// ----------------------------------------------------------------------------
module uart_interrupt_transfer_engine
   import uite_pkg::*;
#(
   parameter int SEND_DEPTH = SEND_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // load_byte[7:0], receive_count[23:8], flag_tx_empty[24], flag_rx_full[25],
   // flag_tx_complete[26], flag_rx_error[27], rx_byte[35:28], zero[39:36]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,   // load_last
   input  logic [ACTION_W-1:0]   req_tuser,   // action[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // cmd_status[1:0], send_valid[2], send_byte[10:3], store_valid[11],
   // store_index[27:12], store_byte[35:28], txe_irq_enable[36],
   // tc_irq_enable[37], rxne_irq_enable[38], clear_tc[39], sending[40],
   // receiving[41], zero[47:42]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int ADDR_W = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
   localparam int CNT_W  = $clog2(SEND_DEPTH + 1);

   item_type          item_ff;
   logic              item_valid_ff;
   result_type        result_ff;
   result_type        result;
   logic              rsp_valid_ff;
   logic              advance;
   logic              process;

   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [BYTE_W-1:0] rd_data;
   logic              bypass_ff;
   logic [BYTE_W-1:0] bypass_data_ff;

   // advance the pipeline whenever the result register is free or drains
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = item_valid_ff && advance;
   assign req_tready = !item_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.action           <= action_type'(req_tuser);
         item_ff.load_byte        <= req_tdata[7:0];
         item_ff.load_last        <= req_tlast;
         item_ff.receive_count    <= req_tdata[23:8];
         item_ff.flag_tx_empty    <= req_tdata[24];
         item_ff.flag_rx_full     <= req_tdata[25];
         item_ff.flag_tx_complete <= req_tdata[26];
         item_ff.flag_rx_error    <= req_tdata[27];
         item_ff.rx_byte          <= req_tdata[35:28];
      end
   end

   uite_core #(
      .SEND_DEPTH (SEND_DEPTH),
      .ADDR_W     (ADDR_W),
      .CNT_W      (CNT_W)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .process (process),
      .item    (item_ff),
      .rd_data (rd_data),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .result  (result)
   );

   uite_ram #(
      .WIDTH  (BYTE_W),
      .DEPTH  (SEND_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_send_buffer (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // forward a byte written to the entry being prefetched in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else begin
         bypass_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      bypass_data_ff <= wr_data;
   end

   assign rd_data = bypass_ff ? bypass_data_ff : ram_rd_data;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0,
                        result_ff.receiving,
                        result_ff.sending,
                        result_ff.clear_tc,
                        result_ff.rxne_irq_enable,
                        result_ff.tc_irq_enable,
                        result_ff.txe_irq_enable,
                        result_ff.store_byte,
                        result_ff.store_index,
                        result_ff.store_valid,
                        result_ff.send_byte,
                        result_ff.send_valid,
                        result_ff.cmd_status};

endmodule

/* sim/uart_interrupt_transfer_engine_test.sv */
// ----------------------------------------------------------------------------
// UART interrupt transfer engine regression
// Drives transmit loads, receive starts and aborts, and UART status events
// into the engine, predicts every result item, and checks each one field by
// field as it leaves the result channel.
// ----------------------------------------------------------------------------

class transfer_checker;

   // predicted engine state
   bit [7:0]  send_mem [uite_pkg::SEND_DEPTH_DEFAULT];
   bit [8:0]  load_cnt;
   bit [8:0]  send_len;
   bit [8:0]  send_pos;
   bit        send_busy;
   bit        send_armed;
   bit        txe_en;
   bit        tc_en;
   bit        recv_armed;
   bit        recv_busy;
   bit        rxne_en;
   bit [15:0] recv_len;
   bit [15:0] recv_pos;

   uite_pkg::result_type pending_results[$];
   int errors;
   int results_checked;

   task report(string msg);
      $display("result %0d: %s", results_checked, msg);
      errors++;
   endtask

   // Advance the predicted engine by one accepted item and queue its result.
   function void note_item(uite_pkg::item_type it);
      uite_pkg::result_type  r;
      uite_pkg::status_type  st;
      r  = '0;
      st = uite_pkg::ST_OK;
      case (it.action)
         uite_pkg::ACT_LOAD: begin
            if (!it.load_last) begin
               if (send_busy)
                  st = uite_pkg::ST_BUSY;
               else if (int'(load_cnt) >= uite_pkg::SEND_DEPTH_DEFAULT)
                  st = uite_pkg::ST_INVALID;
               else begin
                  send_mem[load_cnt[7:0]] = it.load_byte;
                  load_cnt++;
               end
            end else if (int'(load_cnt) + 1 > uite_pkg::SEND_DEPTH_DEFAULT) begin
               load_cnt = '0;
               st = uite_pkg::ST_INVALID;
            end else begin
               send_armed = 1'b1;
               if (send_busy) begin
                  load_cnt = '0;
                  st = uite_pkg::ST_BUSY;
               end else begin
                  send_mem[load_cnt[7:0]] = it.load_byte;
                  send_len  = load_cnt + 9'd1;
                  send_pos  = '0;
                  send_busy = 1'b1;
                  txe_en    = 1'b1;
                  load_cnt  = '0;
               end
            end
         end
         uite_pkg::ACT_RX_START: begin
            if (it.receive_count == '0)
               st = uite_pkg::ST_INVALID;
            else begin
               recv_armed = 1'b1;
               if (recv_busy)
                  st = uite_pkg::ST_BUSY;
               else begin
                  recv_len  = it.receive_count;
                  recv_pos  = '0;
                  recv_busy = 1'b1;
                  rxne_en   = 1'b1;
               end
            end
         end
         uite_pkg::ACT_RX_ABORT: begin
            rxne_en    = 1'b0;
            recv_armed = 1'b0;
            recv_len   = '0;
            recv_pos   = '0;
            recv_busy  = 1'b0;
         end
         default: begin
            // transmit empty first, then receive, then transmission complete
            if (send_armed && it.flag_tx_empty) begin
               if (send_pos < send_len && int'(send_pos) < uite_pkg::SEND_DEPTH_DEFAULT) begin
                  r.send_valid = 1'b1;
                  r.send_byte  = send_mem[send_pos[7:0]];
                  send_pos++;
               end else begin
                  txe_en = 1'b0;
                  tc_en  = 1'b1;
               end
            end
            if (recv_armed && it.flag_rx_full) begin
               if (it.flag_rx_error) begin
                  rxne_en   = 1'b0;
                  recv_busy = 1'b0;
               end else if (recv_busy && recv_pos < recv_len) begin
                  r.store_valid = 1'b1;
                  r.store_index = recv_pos;
                  r.store_byte  = it.rx_byte;
                  recv_pos++;
                  if (recv_pos >= recv_len) begin
                     rxne_en   = 1'b0;
                     recv_busy = 1'b0;
                  end
               end
            end
            if (send_armed && it.flag_tx_complete && send_pos >= send_len) begin
               tc_en       = 1'b0;
               r.clear_tc  = 1'b1;
               send_busy   = 1'b0;
            end
         end
      endcase
      r.cmd_status      = st;
      r.txe_irq_enable  = txe_en;
      r.tc_irq_enable   = tc_en;
      r.rxne_irq_enable = rxne_en;
      r.sending         = send_busy;
      r.receiving       = recv_busy;
      pending_results.push_back(r);
   endfunction

   task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
         report($sformatf("%s got %h want %h", name, got, want));
   endtask

   task check_result(uite_pkg::result_type got);
      uite_pkg::result_type want;
      if (pending_results.size() == 0) begin
         report("result item with nothing outstanding");
         results_checked++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("cmd_status",      16'(got.cmd_status),      16'(want.cmd_status));
      compare_field("send_valid",      16'(got.send_valid),      16'(want.send_valid));
      compare_field("send_byte",       16'(got.send_byte),       16'(want.send_byte));
      compare_field("store_valid",     16'(got.store_valid),     16'(want.store_valid));
      compare_field("store_index",     got.store_index,          want.store_index);
      compare_field("store_byte",      16'(got.store_byte),      16'(want.store_byte));
      compare_field("txe_irq_enable",  16'(got.txe_irq_enable),  16'(want.txe_irq_enable));
      compare_field("tc_irq_enable",   16'(got.tc_irq_enable),   16'(want.tc_irq_enable));
      compare_field("rxne_irq_enable", 16'(got.rxne_irq_enable), 16'(want.rxne_irq_enable));
      compare_field("clear_tc",        16'(got.clear_tc),        16'(want.clear_tc));
      compare_field("sending",         16'(got.sending),         16'(want.sending));
      compare_field("receiving",       16'(got.receiving),       16'(want.receiving));
      results_checked++;
   endtask

endclass

module uart_interrupt_transfer_engine_test;
   import uite_pkg::*;

   localparam int TOTAL_ITEMS = 1050;
   localparam int CALM_ITEMS  = 150;

   // status flag positions in the flags argument of make_item
   localparam logic [3:0] F_TXE  = 4'b0001;
   localparam logic [3:0] F_RXNE = 4'b0010;
   localparam logic [3:0] F_TC   = 4'b0100;
   localparam logic [3:0] F_ERR  = 4'b1000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic [ACTION_W-1:0]   req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   transfer_checker board = new();

   int items_issued = 0;
   bit gap_mode     = 1'b1;  // sender idles in bursts while set
   bit stall_mode   = 1'b1;  // receiver stalls in bursts while set
   bit calm         = 1'b0;  // no idling on either side near the end
   int stall_left   = 0;

   uart_interrupt_transfer_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Build one item; flags are {error, tx complete, rx full, tx empty}.
   function automatic item_type make_item(action_type a, logic [7:0] b, logic last,
                                          logic [15:0] count, logic [3:0] flags,
                                          logic [7:0] rbyte);
      item_type it;
      it.action           = a;
      it.load_byte        = b;
      it.load_last        = last;
      it.receive_count    = count;
      it.flag_tx_empty    = flags[0];
      it.flag_rx_full     = flags[1];
      it.flag_tx_complete = flags[2];
      it.flag_rx_error    = flags[3];
      it.rx_byte          = rbyte;
      return it;
   endfunction

   // Present one item, hold it until accepted, then note it for prediction.
   // An idle burst, if any, comes before the item so tvalid sees one
   // assignment per edge.
   task automatic issue(item_type it);
      if ($urandom_range(0, 39) == 0)
         gap_mode = !gap_mode;
      if (!calm && gap_mode && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, it.rx_byte, it.flag_rx_error, it.flag_tx_complete,
                     it.flag_rx_full, it.flag_tx_empty, it.receive_count, it.load_byte};
      req_tlast  <= it.load_last;
      req_tuser  <= it.action;
      do @(posedge clock); while (!req_tready);
      board.note_item(it);
      items_issued++;
   endtask

   // Load n transmit bytes; the final one carries tlast when with_last is set.
   task automatic load_bytes(int n, bit with_last);
      for (int i = 0; i < n; i++)
         issue(make_item(ACT_LOAD, 8'($urandom), with_last && (i == n - 1), 16'($urandom),
                         4'($urandom), 8'($urandom)));
   endtask

   // Feed UART events until the running send finishes. Mostly TXE, TC only
   // rarely before every byte is out, plus stray loads and receive traffic.
   task automatic drain_send();
      int         guard;
      logic [3:0] fl;
      guard = 0;
      while (board.send_busy && guard < 2000) begin
         if ($urandom_range(0, 11) == 0)
            issue(make_item(ACT_LOAD, 8'($urandom), 1'($urandom), 16'($urandom),
                            4'($urandom), 8'($urandom)));
         else begin
            fl    = 4'($urandom);
            fl[0] = ($urandom_range(0, 5) != 0);
            fl[2] = (board.send_pos >= board.send_len) ? 1'($urandom_range(0, 1))
                                                       : ($urandom_range(0, 7) == 0);
            fl[3] = ($urandom_range(0, 7) == 0);
            issue(make_item(ACT_EVENT, 8'($urandom), 1'($urandom), 16'($urandom), fl,
                            8'($urandom)));
         end
         guard++;
      end
   endtask

   // Start a receive of count bytes and feed it events until it stops,
   // with the odd second start, abort and error thrown in.
   task automatic run_receive(logic [15:0] count);
      int         guard;
      logic [3:0] fl;
      if (board.recv_busy && $urandom_range(0, 1) == 0)
         issue(make_item(ACT_RX_ABORT, 8'($urandom), 1'($urandom), 16'($urandom),
                         4'($urandom), 8'($urandom)));
      issue(make_item(ACT_RX_START, 8'($urandom), 1'($urandom), count, 4'($urandom),
                      8'($urandom)));
      guard = 0;
      while (board.recv_busy && guard < 40) begin
         case ($urandom_range(0, 19))
            0: issue(make_item(ACT_RX_START, 8'($urandom), 1'($urandom),
                               16'($urandom_range(0, 9)), 4'($urandom), 8'($urandom)));
            1: issue(make_item(ACT_RX_ABORT, 8'($urandom), 1'($urandom), 16'($urandom),
                               4'($urandom), 8'($urandom)));
            default: begin
               fl    = 4'($urandom);
               fl[1] = ($urandom_range(0, 4) != 0);
               fl[3] = ($urandom_range(0, 11) == 0);
               issue(make_item(ACT_EVENT, 8'($urandom), 1'($urandom), 16'($urandom), fl,
                               8'($urandom)));
            end
         endcase
         guard++;
      end
      // leave long receives running now and then
      if (board.recv_busy && $urandom_range(0, 3) != 0)
         issue(make_item(ACT_RX_ABORT, 8'($urandom), 1'($urandom), 16'($urandom),
                         4'($urandom), 8'($urandom)));
   endtask

   function automatic int msg_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
   endfunction

   function automatic logic [15:0] rx_count();
      if ($urandom_range(0, 9) == 0)
         return 16'($urandom);
      if ($urandom_range(0, 14) == 0)
         return '0;
      return 16'($urandom_range(1, 8));
   endfunction

   // Result side: check every accepted result, stall in random bursts.
   always @(posedge clock) begin : rsp_side
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rsp_tdata[RSP_DATA_W-1:42] !== '0)
               board.report("nonzero padding in result item");
            got.cmd_status      = status_type'(rsp_tdata[1:0]);
            got.send_valid      = rsp_tdata[2];
            got.send_byte       = rsp_tdata[10:3];
            got.store_valid     = rsp_tdata[11];
            got.store_index     = rsp_tdata[27:12];
            got.store_byte      = rsp_tdata[35:28];
            got.txe_irq_enable  = rsp_tdata[36];
            got.tc_irq_enable   = rsp_tdata[37];
            got.rxne_irq_enable = rsp_tdata[38];
            got.clear_tc        = rsp_tdata[39];
            got.sending         = rsp_tdata[40];
            got.receiving       = rsp_tdata[41];
            board.check_result(got);
         end
         if ($urandom_range(0, 199) == 0)
            stall_mode = !stall_mode;
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left = stall_left - 1;
         end else if (!calm && stall_mode && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 12);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all flags while nothing is armed, then invalid start and idle abort
      issue(make_item(ACT_EVENT, 8'hFF, 1'b1, 16'hFFFF, F_TXE | F_RXNE | F_TC | F_ERR, 8'hFF));
      issue(make_item(ACT_RX_START, 8'h00, 1'b0, 16'h0000, 4'b0, 8'h00));
      issue(make_item(ACT_RX_ABORT, 8'h00, 1'b0, 16'h0000, 4'b0, 8'h00));
      // two-byte send, loads rejected while it runs
      issue(make_item(ACT_LOAD, 8'h00, 1'b0, 16'h0000, 4'b0, 8'h00));
      issue(make_item(ACT_LOAD, 8'hFF, 1'b1, 16'h0000, 4'b0, 8'h00));
      issue(make_item(ACT_LOAD, 8'h5A, 1'b1, 16'h0000, 4'b0, 8'h00));
      issue(make_item(ACT_LOAD, 8'h33, 1'b0, 16'h0000, 4'b0, 8'h00));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TXE, 8'h00));
      // TC too early must be ignored
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TC, 8'h00));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TXE, 8'h00));
      // buffer exhausted: TXE enable off, TC enable on, then TC ends the send
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TXE, 8'h00));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TC, 8'h00));
      // TXE while idle raises TC enable again
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TXE, 8'h00));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TC, 8'h00));
      // largest receive, a busy start, two stores, then an error stop
      issue(make_item(ACT_RX_START, 8'h00, 1'b0, 16'hFFFF, 4'b0, 8'h00));
      issue(make_item(ACT_RX_START, 8'h00, 1'b0, 16'h0003, 4'b0, 8'h00));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_RXNE, 8'h00));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_RXNE, 8'hFF));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_RXNE | F_ERR, 8'h11));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_RXNE | F_ERR, 8'h22));
      // short receive completing on count, with TXE and TC on the same event
      issue(make_item(ACT_RX_START, 8'h00, 1'b0, 16'h0002, 4'b0, 8'h00));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_TXE | F_RXNE | F_TC, 8'hA5));
      issue(make_item(ACT_EVENT, 8'h00, 1'b0, 16'h0000, F_RXNE, 8'h5A));
      issue(make_item(ACT_RX_START, 8'h00, 1'b0, 16'h0001, 4'b0, 8'h00));
      issue(make_item(ACT_RX_ABORT, 8'h00, 1'b0, 16'h0000, 4'b0, 8'h00));

      // full-depth message, then overflow of both a plain and a last load
      load_bytes(SEND_DEPTH_DEFAULT, 1'b1);
      drain_send();
      load_bytes(SEND_DEPTH_DEFAULT + 1, 1'b0);
      load_bytes(1, 1'b1);

      while (items_issued < TOTAL_ITEMS) begin
         calm = (items_issued > TOTAL_ITEMS - CALM_ITEMS);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               if (board.send_busy)
                  drain_send();
               load_bytes(msg_len(), 1'b1);
               drain_send();
            end
            4, 5, 6: run_receive(rx_count());
            7: begin
               // overlap a receive with a send
               issue(make_item(ACT_RX_START, 8'($urandom), 1'($urandom),
                               16'($urandom_range(1, 12)), 4'($urandom), 8'($urandom)));
               load_bytes(msg_len(), 1'b1);
               drain_send();
            end
            default: begin
               repeat ($urandom_range(1, 4))
                  issue(make_item(action_type'($urandom_range(0, 3)), 8'($urandom),
                                  1'($urandom), 16'($urandom), 4'($urandom),
                                  8'($urandom)));
            end
         endcase
      end
      calm = 1'b1;
      req_tvalid <= 1'b0;

      while (board.pending_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (board.errors == 0)
         $display("uart_interrupt_transfer_engine regression: pass");
      else
         $display("uart_interrupt_transfer_engine regression: fail");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("uart_interrupt_transfer_engine regression: fail");
      $finish;
   end

endmodule
